[rtl/assert_macros.svh]
// assertion macros used by the checker file osc_checker
// clocked on clk, the plain form is disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define OSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define OSC_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/osc_pkg.sv]
// object steering command: shared constants, widths and stage types
// no dependencies
`timescale 1ns / 1ps

package osc_pkg;

  // fraction bits of the drive commands
  localparam int FRAC_BITS = 12;

  // detected classes
  localparam logic [7:0] ID_LEFT  = 8'd3;
  localparam logic [7:0] ID_UP    = 8'd4;
  localparam logic [7:0] ID_DOWN  = 8'd6;
  localparam logic [7:0] ID_SMILE = 8'd9;

  // register map, index is paddr[3:2]
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_MAX_TURN = 2'd1;
  localparam logic [1:0] REG_MIN_TURN = 2'd2;

  localparam int CX_W   = 12;
  localparam int RATE_W = 14;
  localparam int FWD_W  = 14;
  localparam int TURN_W = 15;

  localparam logic [CX_W-1:0]   CENTER_X_RST = 12'd320;
  localparam logic [RATE_W-1:0] MAX_TURN_RST = 14'd2458;
  localparam logic [RATE_W-1:0] MIN_TURN_RST = 14'd1638;

  // projection datapath widths
  localparam int NUM_W    = 45;              // corner numerator / denominator
  localparam int MAG_W    = NUM_W - 1;
  localparam int QFRAC    = 16;
  localparam int DVD_W    = MAG_W + QFRAC;   // big divider dividend and quotient
  localparam int Q_W      = DVD_W + 1;       // signed projected x
  localparam int SUM_W    = Q_W + 2;
  localparam int XP_SHIFT = QFRAC + 2;       // to pixels, then divide by four
  localparam int XP_W     = SUM_W - XP_SHIFT;
  localparam int DIFF_W   = XP_W + 1;
  localparam int CLAMP_W  = 27;              // beyond 2^25 the rate is saturated
  localparam int PROD_W   = CLAMP_W + RATE_W + 3;
  localparam int ANUM_W   = RATE_W + CX_W;   // small divider dividend

  typedef enum logic [1:0] {
    TM_ZERO,
    TM_POS,
    TM_NEG,
    TM_DIV
  } turn_mode_t;

  typedef struct packed {
    logic              v;
    logic              smile;
    logic [FWD_W-1:0]  fwd;
    logic [TURN_W-1:0] turn;
  } side_t;

  typedef struct packed {
    side_t      s;
    logic [3:0] neg;
    logic [3:0] dz;
  } big_side_t;

  typedef struct packed {
    side_t      s;
    turn_mode_t mode;
    logic       neg;
  } small_side_t;

endpackage

[rtl/osc_div.sv]
// pipelined restoring divider, one quotient bit per stage, unsigned
// no dependencies; advances when en is high
`timescale 1ns / 1ps

module osc_div #(
  parameter int DVD_W = 60,
  parameter int DVS_W = 44
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient
);

  logic [DVS_W-1:0] rem [DVD_W];
  logic [DVD_W-1:0] dq  [DVD_W];   // dividend shifts out, quotient shifts in
  logic [DVS_W-1:0] dvs [DVD_W];

  for (genvar s = 0; s < DVD_W; s++) begin : g_step
    logic [DVS_W-1:0] rin;
    logic [DVS_W-1:0] vin;
    logic [DVD_W-1:0] qin;
    logic [DVS_W:0]   sh;
    logic [DVS_W+1:0] diff;

    if (s == 0) begin : g_first
      assign rin = '0;
      assign qin = dividend;
      assign vin = divisor;
    end else begin : g_next
      assign rin = rem[s-1];
      assign qin = dq[s-1];
      assign vin = dvs[s-1];
    end

    assign sh   = {rin, qin[DVD_W-1]};
    assign diff = {1'b0, sh} - {2'b00, vin};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= diff[DVS_W+1] ? sh[DVS_W-1:0] : diff[DVS_W-1:0];
        dq[s]  <= {qin[DVD_W-2:0], ~diff[DVS_W+1]};
        dvs[s] <= vin;
      end
    end
  end

  assign quotient = dq[DVD_W-1];

endmodule

[rtl/object_steering_command.sv]
// object steering command top level: register port, projection pipeline, turn law
// depends on osc_pkg and osc_div
//
//  channel | signals                                   | direction
//  det     | det_valid, det_stall, object_id .. hom_*  | detection in
//  cmd     | cmd_valid, cmd_stall, forward_speed, turn_rate | drive command out
//  apb     | psel, penable, pwrite, paddr, pwdata, ... | register access
//
// one detection per cycle while no stalled command holds the pipeline; the path runs through
// stages a to c, the corner division (one quotient bit per stage), e to j and the turn division
// rst is synchronous and empties the pipeline, registers return to their reset values
// a stalled command freezes the whole pipeline, det_stall rises only then
`timescale 1ns / 1ps

module object_steering_command
  import osc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     det_valid,
  output logic                     det_stall,
  input  logic [7:0]               object_id,
  input  logic [11:0]              obj_width,
  input  logic [11:0]              obj_height,
  input  logic signed [31:0]       hom_r0c0,
  input  logic signed [31:0]       hom_r1c0,
  input  logic signed [31:0]       hom_r2c0,
  input  logic signed [31:0]       hom_r0c1,
  input  logic signed [31:0]       hom_r1c1,
  input  logic signed [31:0]       hom_r2c1,
  input  logic signed [31:0]       hom_r0c2,
  input  logic signed [31:0]       hom_r1c2,
  input  logic signed [31:0]       hom_r2c2,
  output logic                     cmd_valid,
  input  logic                     cmd_stall,
  output logic signed [FWD_W-1:0]  forward_speed,
  output logic signed [TURN_W-1:0] turn_rate
);

  localparam int ONE = 1 << FRAC_BITS;
  localparam logic [FWD_W-1:0]  FWD_ONE   = FWD_W'(ONE);
  localparam logic [FWD_W-1:0]  FWD_BACK  = FWD_W'(-ONE);
  localparam logic [FWD_W-1:0]  FWD_SMILE = FWD_W'((ONE + 5) / 10);
  localparam logic [TURN_W-1:0] TURN_ONE  = TURN_W'(ONE);
  localparam logic signed [DIFF_W-1:0] D_HI = DIFF_W'(2 ** (CLAMP_W - 2));
  localparam logic signed [DIFF_W-1:0] D_LO = -D_HI;

  // ---------------- registers ----------------
  logic [CX_W-1:0]   center_x;
  logic [RATE_W-1:0] max_turn_rate;
  logic [RATE_W-1:0] min_turn_rate;
  logic [CX_W-1:0]   c_eff;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign c_eff  = (center_x == '0) ? CX_W'(1) : center_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= CENTER_X_RST;
      max_turn_rate <= MAX_TURN_RST;
      min_turn_rate <= MIN_TURN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_CENTER_X: center_x      <= pwdata[CX_W-1:0];
        REG_MAX_TURN: max_turn_rate <= pwdata[RATE_W-1:0];
        REG_MIN_TURN: min_turn_rate <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_CENTER_X: prdata = 32'(center_x);
      REG_MAX_TURN: prdata = 32'(max_turn_rate);
      REG_MIN_TURN: prdata = 32'(min_turn_rate);
      default:      prdata = '0;
    endcase
  end

  // whole pipeline moves unless the output register holds an untaken command
  logic en;
  assign en        = !(cmd_valid && cmd_stall);
  assign det_stall = !en;

  // ---------------- stage a: class decode and corner products ----------------
  side_t in_side;
  logic signed [12:0] w_s;
  logic signed [12:0] h_s;

  assign w_s = $signed({1'b0, obj_width});
  assign h_s = $signed({1'b0, obj_height});

  always_comb begin
    in_side.v     = det_valid;
    in_side.smile = (object_id == ID_SMILE);
    in_side.fwd   = '0;
    in_side.turn  = '0;
    case (object_id)
      ID_LEFT:  in_side.turn = TURN_ONE;
      ID_UP:    in_side.fwd  = FWD_ONE;
      ID_DOWN:  in_side.fwd  = FWD_BACK;
      ID_SMILE: in_side.fwd  = FWD_SMILE;
      default: ;
    endcase
  end

  side_t a_s;
  logic signed [NUM_W-1:0] a_nw, a_nh, a_dw, a_dh, a_n0, a_d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_s.v <= 1'b0;
    end else if (en) begin
      a_s <= in_side;
    end
    if (en) begin
      a_nw <= hom_r0c0 * w_s;
      a_nh <= hom_r0c1 * h_s;
      a_dw <= hom_r2c0 * w_s;
      a_dh <= hom_r2c1 * h_s;
      a_n0 <= hom_r0c2;
      a_d0 <= hom_r2c2;
    end
  end

  // ---------------- stage b: corner sums ----------------
  side_t b_s;
  logic signed [NUM_W-1:0] b_n [4];
  logic signed [NUM_W-1:0] b_d [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_s.v <= 1'b0;
    end else if (en) begin
      b_s <= a_s;
    end
    if (en) begin
      // corners (0,0), (w,0), (0,h), (w,h)
      b_n[0] <= a_n0;
      b_n[1] <= a_nw + a_n0;
      b_n[2] <= a_nh + a_n0;
      b_n[3] <= a_nw + a_nh + a_n0;
      b_d[0] <= a_d0;
      b_d[1] <= a_dw + a_d0;
      b_d[2] <= a_dh + a_d0;
      b_d[3] <= a_dw + a_dh + a_d0;
    end
  end

  // ---------------- stage c: sign and magnitude ----------------
  big_side_t c_bs;
  logic [MAG_W-1:0] c_mn [4];
  logic [MAG_W-1:0] c_md [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_bs.s.v <= 1'b0;
    end else if (en) begin
      c_bs.s <= b_s;
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        c_mn[k]     <= b_n[k][NUM_W-1] ? MAG_W'(-b_n[k]) : MAG_W'(b_n[k]);
        c_md[k]     <= b_d[k][NUM_W-1] ? MAG_W'(-b_d[k]) : MAG_W'(b_d[k]);
        c_bs.neg[k] <= b_n[k][NUM_W-1] ^ b_d[k][NUM_W-1];
        c_bs.dz[k]  <= (b_d[k] == '0);
      end
    end
  end

  // ---------------- corner division ----------------
  logic [DVD_W-1:0] big_q [4];
  big_side_t bs [DVD_W];

  for (genvar k = 0; k < 4; k++) begin : g_corner
    osc_div #(
      .DVD_W (DVD_W),
      .DVS_W (MAG_W)
    ) u_div (
      .clk      (clk),
      .en       (en),
      .dividend ({c_mn[k], {QFRAC{1'b0}}}),
      .divisor  (c_md[k]),
      .quotient (big_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DVD_W; i++) bs[i].s.v <= 1'b0;
    end else if (en) begin
      bs[0] <= c_bs;
      for (int i = 1; i < DVD_W; i++) bs[i] <= bs[i-1];
    end
  end

  // ---------------- stage e: signed projected x ----------------
  side_t e_s;
  logic signed [Q_W-1:0] e_q [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_s.v <= 1'b0;
    end else if (en) begin
      e_s <= bs[DVD_W-1].s;
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        // zero projective weight projects to x = 0
        if (bs[DVD_W-1].dz[k]) begin
          e_q[k] <= '0;
        end else if (bs[DVD_W-1].neg[k]) begin
          e_q[k] <= -$signed({1'b0, big_q[k]});
        end else begin
          e_q[k] <= $signed({1'b0, big_q[k]});
        end
      end
    end
  end

  // ---------------- stage f: sum of corners ----------------
  side_t f_s;
  logic signed [SUM_W-1:0] f_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_s.v <= 1'b0;
    end else if (en) begin
      f_s <= e_s;
    end
    if (en) begin
      f_sum <= SUM_W'(e_q[0]) + SUM_W'(e_q[1]) + SUM_W'(e_q[2]) + SUM_W'(e_q[3]);
    end
  end

  // ---------------- stage g: pixel position, truncated toward zero ----------------
  side_t g_s;
  logic signed [XP_W-1:0] g_xp;
  logic [SUM_W-1:0] sum_mag;
  logic [XP_W-1:0]  xp_mag;

  assign sum_mag = f_sum[SUM_W-1] ? SUM_W'(-f_sum) : SUM_W'(f_sum);
  assign xp_mag  = sum_mag[SUM_W-1:XP_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_s.v <= 1'b0;
    end else if (en) begin
      g_s <= f_s;
    end
    if (en) begin
      g_xp <= f_sum[SUM_W-1] ? -$signed(xp_mag) : $signed(xp_mag);
    end
  end

  // ---------------- stage h: offset from center, clamped ----------------
  side_t h_s_r;
  logic signed [CLAMP_W-1:0] h_d;
  logic signed [DIFF_W-1:0]  dff;

  assign dff = DIFF_W'($signed({1'b0, c_eff})) - DIFF_W'(g_xp);

  always_ff @(posedge clk) begin
    if (rst) begin
      h_s_r.v <= 1'b0;
    end else if (en) begin
      h_s_r <= g_s;
    end
    if (en) begin
      if (dff > D_HI) begin
        h_d <= CLAMP_W'(D_HI);
      end else if (dff < D_LO) begin
        h_d <= CLAMP_W'(D_LO);
      end else begin
        h_d <= CLAMP_W'(dff);
      end
    end
  end

  // ---------------- stage i: raw numerator and thresholds ----------------
  side_t i_s;
  logic signed [PROD_W-1:0] i_num;
  logic [ANUM_W-1:0] i_thmx;
  logic [ANUM_W-1:0] i_thmn;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_s.v <= 1'b0;
    end else if (en) begin
      i_s <= h_s_r;
    end
    if (en) begin
      i_num  <= h_d * $signed({1'b0, max_turn_rate, 2'b00});
      i_thmx <= max_turn_rate * c_eff;
      i_thmn <= min_turn_rate * c_eff;
    end
  end

  // ---------------- stage j: dead band and saturation decision ----------------
  small_side_t j_ss;
  logic [ANUM_W-1:0] j_anum;
  logic [PROD_W-1:0] anum;
  turn_mode_t mode_next;

  assign anum = i_num[PROD_W-1] ? PROD_W'(-i_num) : PROD_W'(i_num);

  always_comb begin
    // dead band is checked before saturation
    if ({anum, 1'b0} <= (PROD_W+1)'(i_thmn)) begin
      mode_next = TM_ZERO;
    end else if (i_num >= $signed({1'b0, i_thmx})) begin
      mode_next = TM_POS;
    end else if (i_num <= -$signed({1'b0, i_thmx})) begin
      mode_next = TM_NEG;
    end else begin
      mode_next = TM_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_ss.s.v <= 1'b0;
    end else if (en) begin
      j_ss.s <= i_s;
    end
    if (en) begin
      j_ss.mode <= mode_next;
      j_ss.neg  <= i_num[PROD_W-1];
      j_anum    <= anum[ANUM_W-1:0];
    end
  end

  // ---------------- turn division ----------------
  logic [ANUM_W-1:0] small_q;
  small_side_t ss [ANUM_W];

  osc_div #(
    .DVD_W (ANUM_W),
    .DVS_W (CX_W)
  ) u_turn_div (
    .clk      (clk),
    .en       (en),
    .dividend (j_anum),
    .divisor  (c_eff),
    .quotient (small_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ANUM_W; i++) ss[i].s.v <= 1'b0;
    end else if (en) begin
      ss[0] <= j_ss;
      for (int i = 1; i < ANUM_W; i++) ss[i] <= ss[i-1];
    end
  end

  // ---------------- output register ----------------
  small_side_t last;
  logic [TURN_W-1:0] turn_next;
  logic [TURN_W-1:0] q_turn;

  assign last   = ss[ANUM_W-1];
  assign q_turn = {1'b0, small_q[RATE_W-1:0]};

  always_comb begin
    turn_next = last.s.turn;
    if (last.s.smile) begin
      case (last.mode)
        TM_ZERO: turn_next = '0;
        TM_POS:  turn_next = {1'b0, max_turn_rate};
        TM_NEG:  turn_next = -{1'b0, max_turn_rate};
        default: turn_next = last.neg ? -q_turn : q_turn;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (en) begin
      cmd_valid <= last.s.v;
    end
    if (en) begin
      forward_speed <= $signed(last.s.fwd);
      turn_rate     <= $signed(turn_next);
    end
  end

endmodule

[rtl/osc_checker.sv]
// port-level checks for object_steering_command, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module osc_checker (
  input logic        clk,
  input logic        rst,
  input logic        det_valid,
  input logic        det_stall,
  input logic        cmd_valid,
  input logic        cmd_stall,
  input logic [13:0] forward_speed,
  input logic [14:0] turn_rate
);

  // reset leaves an empty pipeline that takes detections at once
  `OSC_ASSERT_NORST(a_reset_empty, rst |=> !cmd_valid && !det_stall, "not empty after reset")

  // input backs up only behind an untaken command
  `OSC_ASSERT(a_stall_cause, det_stall |-> cmd_valid && cmd_stall, "stall without backup")

  // a command disappears only through a transfer
  `OSC_ASSERT(a_no_drop, $fell(cmd_valid) |-> $past(!cmd_stall), "command dropped")

  // stalled command holds
  `OSC_ASSERT(a_hold, cmd_valid && cmd_stall |=> cmd_valid && $stable(forward_speed) && $stable(turn_rate), "stalled command changed")

endmodule

bind object_steering_command osc_checker u_osc_checker (.*);

[sim/object_steering_command_test.sv]
// testbench for object_steering_command: random and directed detections, scoreboard check
// depends on osc_pkg and the object_steering_command rtl
`timescale 1ns / 1ps

module object_steering_command_test;
  import osc_pkg::*;

  typedef struct {
    logic [7:0]         id;
    logic [11:0]        w;
    logic [11:0]        h;
    logic signed [31:0] m [9];  // column-major, index col*3+row
  } detection_t;

  typedef struct {
    logic [FWD_W-1:0]  fwd;
    logic [TURN_W-1:0] turn;
  } command_t;

  // expected drive commands, computed from each accepted detection
  class steering_scoreboard;
    logic [11:0] cx = 320;
    logic [13:0] max_rate = 2458;
    logic [13:0] min_rate = 1638;
    command_t pending[$];
    int errors = 0;
    int checked = 0;

    function longint corner_x(detection_t d, longint x, longint y);
      longint n, q;
      n = longint'(d.m[0]) * x + longint'(d.m[3]) * y + longint'(d.m[6]);
      q = longint'(d.m[2]) * x + longint'(d.m[5]) * y + longint'(d.m[8]);
      if (q == 0) return 0;
      return (n * 65536) / q;
    endfunction

    function void note_detection(detection_t d);
      command_t c;
      longint fwd, turn, sum, xp, num, anum, cc, mx, mn;
      fwd = 0;
      turn = 0;
      if (d.id == ID_LEFT) turn = 4096;
      else if (d.id == ID_UP) fwd = 4096;
      else if (d.id == ID_DOWN) fwd = -4096;
      else if (d.id == ID_SMILE) begin
        cc = (cx == 0) ? 1 : cx;
        mx = max_rate;
        mn = min_rate;
        sum = corner_x(d, 0, 0) + corner_x(d, d.w, 0) + corner_x(d, 0, d.h)
            + corner_x(d, d.w, d.h);
        xp = (sum / 65536) / 4;
        num = (cc - xp) * 4 * mx;
        anum = num < 0 ? -num : num;
        if (2 * anum <= mn * cc) turn = 0;
        else if (num >= mx * cc) turn = mx;
        else if (num <= -(mx * cc)) turn = -mx;
        else turn = num / cc;
        fwd = 410;
      end
      c.fwd = fwd[FWD_W-1:0];
      c.turn = turn[TURN_W-1:0];
      pending = {pending, c};
    endfunction

    function void check_command(logic [FWD_W-1:0] fwd, logic [TURN_W-1:0] turn);
      command_t e;
      if (pending.size() == 0) begin
        $display("%0t: command with none expected fwd %0d turn %0d", $time, fwd, turn);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (fwd !== e.fwd) begin
        $display("%0t: forward_speed expected %h actual %h", $time, e.fwd, fwd);
        errors++;
      end
      if (turn !== e.turn) begin
        $display("%0t: turn_rate expected %h actual %h", $time, e.turn, turn);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic det_valid = 0, det_stall;
  logic [7:0] object_id = '0;
  logic [11:0] obj_width = '0, obj_height = '0;
  logic signed [31:0] hm [9];
  logic cmd_valid, cmd_stall = 0;
  logic signed [FWD_W-1:0] forward_speed;
  logic signed [TURN_W-1:0] turn_rate;

  steering_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 29;
  int hold_cycles = 0;
  int sent = 0;

  initial for (int i = 0; i < 9; i++) hm[i] = '0;

  always #10 clk = ~clk;

  object_steering_command uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .det_valid, .det_stall, .object_id, .obj_width, .obj_height,
    .hom_r0c0(hm[0]), .hom_r1c0(hm[1]), .hom_r2c0(hm[2]),
    .hom_r0c1(hm[3]), .hom_r1c1(hm[4]), .hom_r2c1(hm[5]),
    .hom_r0c2(hm[6]), .hom_r1c2(hm[7]), .hom_r2c2(hm[8]),
    .cmd_valid, .cmd_stall, .forward_speed, .turn_rate
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("object_steering_command: mismatch");
      $finish;
    end
  end

  // command side: check on transfer, then choose next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) sb.check_command(forward_speed, turn_rate);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        cmd_stall <= 1;
      end else begin
        cmd_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_CENTER_X) sb.cx = v[11:0];
    else if (idx == REG_MAX_TURN) sb.max_rate = v[13:0];
    else sb.min_rate = v[13:0];
  endtask

  task automatic drain;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send(detection_t d);
    while ($urandom_range(99) < idle_pct) begin
      det_valid <= 0;
      @(posedge clk);
    end
    det_valid <= 1;
    object_id <= d.id; obj_width <= d.w; obj_height <= d.h;
    for (int i = 0; i < 9; i++) hm[i] <= d.m[i];
    @(posedge clk);
    while (det_stall) @(posedge clk);
    sb.note_detection(d);
    sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return $urandom_range(3) == 0 ? 32'd0 : 32'($urandom_range(65536 * 4));
      default: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  // mostly plausible homographies: near identity with a shift, sometimes noise
  function automatic detection_t rand_det();
    detection_t d;
    int k;
    k = $urandom_range(99);
    d.id = k < 60 ? ID_SMILE : k < 67 ? ID_LEFT : k < 74 ? ID_UP : k < 81 ? ID_DOWN
         : 8'($urandom());
    d.w = $urandom_range(9) == 0 ? 12'($urandom()) : 12'($urandom_range(200));
    d.h = $urandom_range(9) == 0 ? 12'($urandom()) : 12'($urandom_range(200));
    if ($urandom_range(3) == 0) begin
      for (int i = 0; i < 9; i++) d.m[i] = rand_word();
    end else begin
      d.m[0] = 32'sd65536 + $signed($urandom_range(8192)) - 4096;
      d.m[1] = $signed($urandom_range(64)) - 32;
      d.m[2] = $signed($urandom_range(64)) - 32;
      d.m[3] = $signed($urandom_range(8192)) - 4096;
      d.m[4] = 32'sd65536;
      d.m[5] = $signed($urandom_range(64)) - 32;
      d.m[6] = ($signed($urandom_range(700)) - 50) * 65536 + $signed($urandom_range(65535));
      d.m[7] = $urandom();
      d.m[8] = 32'sd65536 + $signed($urandom_range(1024)) - 512;
    end
    return d;
  endfunction

  initial begin
    detection_t d;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: every class, extreme fields, zero weights
    foreach (d.m[i]) d.m[i] = 0;
    d.w = 0; d.h = 0;
    d.id = ID_LEFT; send(d);
    d.id = ID_UP; send(d);
    d.id = ID_DOWN; send(d);
    d.id = 8'd0; send(d);
    d.id = 8'hff; send(d);
    d.id = ID_SMILE; send(d);   // every weight zero
    d.w = 12'hfff; d.h = 12'hfff;
    foreach (d.m[i]) d.m[i] = 32'h7fff_ffff;
    send(d);
    foreach (d.m[i]) d.m[i] = 32'h8000_0000;
    send(d);
    foreach (d.m[i]) d.m[i] = 32'hffff_ffff;
    send(d);
    d.m[2] = 0; d.m[5] = 0; d.m[8] = 32'sd65536; d.m[6] = 32'sd320 * 65536;
    d.m[0] = 32'sd65536; d.m[3] = 0; d.w = 0; d.h = 0;
    send(d);                    // centered, dead band
    d.m[6] = 32'sd1000 * 65536; send(d);
    d.m[6] = -32'sd1000 * 65536; send(d);
    d.m[6] = 32'sd300 * 65536; send(d);
    det_valid <= 0;
    drain();

    // register extremes, including zero center and zero maximum
    write_reg(REG_CENTER_X, 0);
    write_reg(REG_MAX_TURN, 8192);
    write_reg(REG_MIN_TURN, 0);
    for (int i = 0; i < 120; i++) send(rand_det());
    det_valid <= 0;
    drain();
    write_reg(REG_CENTER_X, 4095);
    write_reg(REG_MAX_TURN, 0);
    write_reg(REG_MIN_TURN, 8192);
    for (int i = 0; i < 60; i++) send(rand_det());
    det_valid <= 0;
    drain();
    write_reg(REG_CENTER_X, 1);
    write_reg(REG_MAX_TURN, 1);
    write_reg(REG_MIN_TURN, 16383);
    for (int i = 0; i < 60; i++) send(rand_det());
    det_valid <= 0;
    drain();
    write_reg(REG_CENTER_X, 32'hffff_f140);
    write_reg(REG_MAX_TURN, 32'hffff_c99a);
    write_reg(REG_MIN_TURN, 32'h0000_0666);

    // long receiver hold while detections keep coming
    hold_cycles <= 300;
    for (int i = 0; i < 150; i++) send(rand_det());
    // stretch with no idling at all
    idle_pct = 0;
    for (int i = 0; i < 200; i++) send(rand_det());
    idle_pct = 29;
    for (int i = 0; i < 450; i++) send(rand_det());
    det_valid <= 0;
    drain();

    $display("sent %0d detections over four register settings, %0d commands checked",
             sent, sb.checked);
    if (sb.errors == 0) $display("object_steering_command: match");
    else $display("object_steering_command: mismatch");
    $finish;
  end

endmodule

[object_steering_command.f]
+incdir+rtl
rtl/osc_pkg.sv
rtl/osc_div.sv
rtl/object_steering_command.sv
rtl/osc_checker.sv
sim/object_steering_command_test.sv
